>>> rtl/core/slfs_pkg.sv
// Package for the segment LCD frame serializer: request kinds, frame constants,
// converter states, the frame hand-off struct and the digit-to-segment table.
// No dependencies.
package slfs_pkg;

	// request kinds
	localparam logic [2:0] KIND_CMD   = 3'd0;
	localparam logic [2:0] KIND_INT   = 3'd1;
	localparam logic [2:0] KIND_HUND  = 3'd2;
	localparam logic [2:0] KIND_TIME  = 3'd3;
	localparam logic [2:0] KIND_CLEAR = 3'd4;

	localparam int MAG_W   = 14;  // magnitude after saturation, up to 9999
	localparam int PAIR_W  = 7;   // a clamped time pair, up to 99
	localparam int FRAME_W = 41;  // longest frame
	localparam int CMD_W   = 12;  // command frame length
	localparam int CNT_W   = 6;   // holds FRAME_W

	localparam logic [3:0]  CMD_PREFIX  = 4'b1000;
	localparam logic [8:0]  DATA_HEADER = 9'h140;
	localparam logic [7:0]  SEG_MINUS   = 8'h02;
	localparam logic [7:0]  SEG_DOT     = 8'h01;
	localparam logic [7:0]  SEG_BLANK   = 8'h00;

	localparam logic signed [31:0] SAT_HI = 32'sd9999;
	localparam logic signed [31:0] SAT_LO = -32'sd999;
	localparam logic [PAIR_W-1:0]  PAIR_MAX = 7'd99;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_DONE
	} conv_state_t;

	// formatted frame handed from the converter to the serializer
	typedef struct packed {
		logic            cmd;
		logic [7:0]      cmd_byte;
		logic [3:0][7:0] seg;       // seg[0] is the leftmost digit
	} frame_t;

	function automatic logic [7:0] seg_of(input logic [3:0] d);
		logic [7:0] s;
		case (d)
			4'd0: s = 8'hFC;
			4'd1: s = 8'h60;
			4'd2: s = 8'hDA;
			4'd3: s = 8'hF2;
			4'd4: s = 8'h66;
			4'd5: s = 8'hB6;
			4'd6: s = 8'hBE;
			4'd7: s = 8'hE0;
			4'd8: s = 8'hFE;
			4'd9: s = 8'hF6;
			default: s = SEG_BLANK;
		endcase
		return s;
	endfunction

endpackage

>>> rtl/core/slfs_req_if.sv
// Request channel of the segment LCD frame serializer.
// Uses no package.
interface slfs_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  command_byte;
	logic signed [31:0] value;
	logic [7:0]  first_pair;
	logic [7:0]  second_pair;

	modport source (output valid, kind, command_byte, value, first_pair, second_pair,
		input ready);
	modport sink (input valid, kind, command_byte, value, first_pair, second_pair,
		output ready);
endinterface

>>> rtl/core/slfs_bit_if.sv
// Serial bit channel of the segment LCD frame serializer.
// Uses no package.
interface slfs_bit_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic last;

	modport source (output valid, data_bit, last, input ready);
	modport sink (input valid, data_bit, last, output ready);
endinterface

>>> rtl/core/segment_lcd_frame_serializer_top.sv
// Segment LCD frame serializer. Each request on req becomes one serial frame
// for a 4-digit seven-segment LCD controller, sent one bit per dout transfer,
// MSB first, with last marking the final bit (release chip select after it).
// A command request gives 12 bits (1000 plus the command byte); integer,
// hundredths, time and clear requests give the 9-bit header 101000000 and
// 32 segment bits. Kinds 5..7 are taken and dropped with no output.
// Flow: the front end converts the saturated value, or the two clamped time
// pairs, to decimal one bit a cycle (command and clear requests skip this
// step) and holds the formatted frame until the shift register frees up. The
// shift register drives one bit per cycle while dout is ready; conversion of
// the next request overlaps the current frame, and with dout always ready
// frames follow each other with no gap, except that an integer or hundredths
// frame right behind a command frame starts late, since its conversion
// outlasts the command frame.
// The request side accepts one request whenever the front end is idle.
// Depends on slfs_pkg, slfs_req_if, slfs_bit_if, slfs_conv and slfs_ser.
module segment_lcd_frame_serializer_top
	import slfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	slfs_req_if.sink   req,
	slfs_bit_if.source dout
);

	// formatted frame between converter and shift register
	frame_t frm;
	logic   frm_valid;
	logic   frm_ready;

	slfs_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm)
	);

	slfs_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.frm_valid (frm_valid),
		.frm_ready (frm_ready),
		.frm       (frm),
		.dout      (dout)
	);

endmodule

>>> rtl/core/slfs_conv.sv
// Request front end: saturation, bit-serial binary to BCD conversion and
// segment formatting. Depends on slfs_pkg and slfs_req_if.
module slfs_conv
	import slfs_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	slfs_req_if.sink      req,
	output logic          frm_valid,
	input  logic          frm_ready,
	output frame_t        frm
);

	conv_state_t state_q, state_d;

	logic [3:0]       cnt_q;
	logic [MAG_W-1:0] bin_q;
	logic [3:0][3:0]  dig_q;    // dig_q[3] thousands .. dig_q[0] units
	logic             neg_q;
	logic [2:0]       kind_q;
	logic [7:0]       cmd_q;

	logic             accept;
	logic signed [31:0] sat;
	logic [MAG_W-1:0] mag;
	logic [PAIR_W-1:0] pa, pb;
	logic             split;
	logic [3:0][3:0]  adj;
	logic [3:0][3:0]  dig_nx;
	logic [3:0][7:0]  seg;

	assign accept = req.valid && req.ready;
	assign split  = (kind_q == KIND_TIME);

	always_comb begin
		if (req.value > SAT_HI) begin
			sat = SAT_HI;
		end else if (req.value < SAT_LO) begin
			sat = SAT_LO;
		end else begin
			sat = req.value;
		end
		mag = sat[31] ? MAG_W'(-sat[MAG_W:0]) : sat[MAG_W-1:0];
		pa  = (req.first_pair  > 8'(PAIR_MAX)) ? PAIR_MAX : req.first_pair[PAIR_W-1:0];
		pb  = (req.second_pair > 8'(PAIR_MAX)) ? PAIR_MAX : req.second_pair[PAIR_W-1:0];
	end

	// one double-dabble step; in time mode the chain breaks between the pairs
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			adj[j] = (dig_q[j] >= 4'd5) ? dig_q[j] + 4'd3 : dig_q[j];
		end
		dig_nx[0] = {adj[0][2:0], split ? bin_q[PAIR_W-1] : bin_q[MAG_W-1]};
		dig_nx[1] = {adj[1][2:0], adj[0][3]};
		dig_nx[2] = {adj[2][2:0], split ? bin_q[MAG_W-1] : adj[1][3]};
		dig_nx[3] = {adj[3][2:0], adj[2][3]};
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		frm_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.kind inside {KIND_CMD, KIND_CLEAR}) begin
						state_d = ST_DONE;
					end else if (req.kind inside {KIND_INT, KIND_HUND, KIND_TIME}) begin
						state_d = ST_CONV;
					end
				end
			end
			ST_CONV: begin
				if (cnt_q == 4'd1) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				frm_valid = 1'b1;
				if (frm_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= req.kind;
			cmd_q  <= req.command_byte;
			neg_q  <= sat[31];
			dig_q  <= '0;
			if (req.kind == KIND_TIME) begin
				bin_q <= {pa, pb};
				cnt_q <= 4'(PAIR_W);
			end else begin
				bin_q <= mag;
				cnt_q <= 4'(MAG_W);
			end
		end else if (state_q == ST_CONV) begin
			dig_q <= dig_nx;
			bin_q <= {bin_q[MAG_W-2:0], 1'b0};
			cnt_q <= cnt_q - 4'd1;
		end
	end

	// segment formatting from the finished digits
	always_comb begin
		seg = '0;
		case (kind_q)
			KIND_INT: begin
				seg[3] = seg_of(dig_q[0]);
				if (dig_q[3] != 4'd0) begin
					seg[0] = seg_of(dig_q[3]);
					seg[1] = seg_of(dig_q[2]);
					seg[2] = seg_of(dig_q[1]);
				end else if (dig_q[2] != 4'd0) begin
					seg[0] = neg_q ? SEG_MINUS : SEG_BLANK;
					seg[1] = seg_of(dig_q[2]);
					seg[2] = seg_of(dig_q[1]);
				end else if (dig_q[1] != 4'd0) begin
					seg[1] = neg_q ? SEG_MINUS : SEG_BLANK;
					seg[2] = seg_of(dig_q[1]);
				end else begin
					seg[2] = neg_q ? SEG_MINUS : SEG_BLANK;
				end
			end
			KIND_HUND: begin
				seg[3] = seg_of(dig_q[0]);
				seg[2] = seg_of(dig_q[1]);
				seg[1] = seg_of(dig_q[2]) | SEG_DOT;
				if (neg_q) begin
					seg[0] = SEG_MINUS;
				end else if (dig_q[3] != 4'd0) begin
					seg[0] = seg_of(dig_q[3]);
				end else begin
					seg[0] = SEG_BLANK;
				end
			end
			KIND_TIME: begin
				seg[0] = seg_of(dig_q[3]);
				seg[1] = seg_of(dig_q[2]) | SEG_DOT;
				seg[2] = seg_of(dig_q[1]) | SEG_DOT;
				seg[3] = seg_of(dig_q[0]);
			end
			default: seg = '0;
		endcase
	end

	assign frm.cmd      = (kind_q == KIND_CMD);
	assign frm.cmd_byte = cmd_q;
	assign frm.seg      = seg;

endmodule

>>> rtl/core/slfs_ser.sv
// Frame shift register: loads a formatted frame and shifts it out MSB first.
// Depends on slfs_pkg and slfs_bit_if.
module slfs_ser
	import slfs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      frm_valid,
	output logic      frm_ready,
	input  frame_t    frm,
	slfs_bit_if.source dout
);

	logic [FRAME_W-1:0] sr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        seg_bits;
	logic               take;
	logic               load;

	// segment bit i*4+j (MSB first) is bit 7-i of digit j
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 4; j++) begin
				seg_bits[31 - (i*4 + j)] = frm.seg[j][7 - i];
			end
		end
	end

	assign dout.valid    = (cnt_q != '0);
	assign dout.data_bit = sr_q[FRAME_W-1];
	assign dout.last     = (cnt_q == CNT_W'(1));
	assign take          = dout.valid && dout.ready;
	assign frm_ready     = (cnt_q == '0) || (take && dout.last);
	assign load          = frm_valid && frm_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= frm.cmd ? CNT_W'(CMD_W) : CNT_W'(FRAME_W);
		end else if (take) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (frm.cmd) begin
				sr_q <= {CMD_PREFIX, frm.cmd_byte, (FRAME_W-CMD_W)'(0)};
			end else begin
				sr_q <= {DATA_HEADER, seg_bits};
			end
		end else if (take) begin
			sr_q <= {sr_q[FRAME_W-2:0], 1'b0};
		end
	end

endmodule
